/* src/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; each macro samples on clock and is disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("port check failed");

// next-cycle implication
`define CHK_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

/* src/psf_pkg.sv */
// shared types, constants and helpers for the prime sieve filter chain
// no dependencies; imported by every module of the block
package psf_pkg;

   localparam int MAX_PRIMES = 64;
   localparam int VALUE_BITS = 16;
   localparam int FIELD_W    = 16;

   localparam int STEP_MAX = (MAX_PRIMES > VALUE_BITS) ? MAX_PRIMES : VALUE_BITS;
   localparam int STEP_W   = $clog2(STEP_MAX + 1);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [FIELD_W-1:0]    field_type;
   typedef logic [STEP_W-1:0]     step_type;

   localparam step_type DIV_LAST  = step_type'(VALUE_BITS - 1);
   localparam step_type COLL_LAST = step_type'(MAX_PRIMES - 1);

   // broadcast from the controller to every cell
   typedef struct packed {
      logic      clear;
      logic      start;
      logic      div_en;
      logic      div_bit;
      logic      collect;
      logic      load;
      value_type load_value;
   } cell_ctrl_type;

   // handed from one cell to the next
   typedef struct packed {
      logic valid;
      logic hit;
   } cell_link_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_COLL = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   function automatic value_type to_value(input field_type x);
      value_type r;
      r = '0;
      for (int i = 0; i < VALUE_BITS; i++) begin
         if (i < FIELD_W) begin
            r[i] = x[i];
         end
      end
      return r;
   endfunction

   function automatic field_type to_field(input value_type x);
      field_type r;
      r = '0;
      for (int i = 0; i < FIELD_W; i++) begin
         if (i < VALUE_BITS) begin
            r[i] = x[i];
         end
      end
      return r;
   endfunction

endpackage

/* src/psf_cell.sv */
// one sieve cell: holds a stored prime, builds a bit-serial remainder
// of the candidate and passes valid and hit flags to its neighbor; uses psf_pkg
module psf_cell
   import psf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_link_type prev,
   output cell_link_type next
);

   logic      valid_ff, valid_in;
   logic      hit_ff, hit_in;
   value_type prime_ff, prime_in;
   value_type rem_ff, rem_in;

   logic [VALUE_BITS:0] shifted;
   logic [VALUE_BITS:0] diff;
   logic                take;
   logic                own_hit;

   assign take    = ctrl.load && !valid_ff && prev.valid;
   assign shifted = {rem_ff, ctrl.div_bit};
   assign diff    = shifted - {1'b0, prime_ff};
   assign own_hit = valid_ff && (rem_ff == '0);

   always_comb begin
      valid_in = valid_ff;
      prime_in = prime_ff;
      rem_in   = rem_ff;
      hit_in   = hit_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (take) begin
         valid_in = 1'b1;
      end
      if (take) begin
         prime_in = ctrl.load_value;
      end
      if (ctrl.start) begin
         rem_in = '0;
         hit_in = 1'b0;
      end else if (ctrl.div_en) begin
         rem_in = diff[VALUE_BITS] ? shifted[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
      end else if (ctrl.collect) begin
         hit_in = prev.hit || own_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
      prime_ff <= prime_in;
      rem_ff   <= rem_in;
   end

   assign next.valid = valid_ff;
   assign next.hit   = hit_ff;

endmodule

/* src/psf_ctrl.sv */
// sequencer for the sieve chain: takes request beats, steps the cells
// through divide and collect, and holds the response beat; uses psf_pkg
module psf_ctrl
   import psf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  field_type     req_value,
   input  logic          req_restart,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output field_type     rsp_prime_value,
   output logic          rsp_overflow,
   input  cell_link_type tail,
   output cell_ctrl_type ctrl
);

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   value_type val_ff, val_in;
   logic      rsp_valid_ff, rsp_valid_in;
   field_type rsp_value_ff, rsp_value_in;
   logic      rsp_ovf_ff, rsp_ovf_in;

   value_type req_v;
   logic      accept;
   logic      slot_free;

   assign req_v     = to_value(req_value);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ctrl         = '0;
      ctrl.div_bit    = val_ff[VALUE_BITS-1];
      ctrl.load_value = val_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.clear = req_restart;
               if (req_v > value_type'(1)) begin
                  ctrl.start = 1'b1;
                  val_in     = req_v;
                  step_in    = '0;
                  state_in   = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            ctrl.div_en = 1'b1;
            val_in      = {val_ff[VALUE_BITS-2:0], val_ff[VALUE_BITS-1]};
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = ST_COLL;
            end else begin
               step_in = step_ff + step_type'(1);
            end
         end
         ST_COLL: begin
            ctrl.collect = 1'b1;
            if (step_ff == COLL_LAST) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + step_type'(1);
            end
         end
         ST_EMIT: begin
            if (tail.hit) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               ctrl.load    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_value_in = to_field(val_ff);
               rsp_ovf_in   = tail.valid;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff       <= val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

/* src/prime_sieve_filter_chain_core.sv */
// Prime sieve stream filter. Each request beat carries a candidate and a restart
// flag; restart empties the prime store first. The candidate is tested against a
// row of MAX_PRIMES cells, each holding one stored prime. A candidate below two
// is dropped in its accept cycle. Otherwise the cells build their remainders one
// candidate bit per cycle, the divide flag then ripples down the row one cell per
// cycle, and a final emit step decides; the next request is taken only after
// that step, later if a response beat is still waiting. A survivor leaves as a
// response beat and fills the next free cell; when every cell is full it leaves
// with overflow set and is not stored. The response register lets a new request
// start while the last response is still pending.
// uses psf_pkg, psf_ctrl and psf_cell
module prime_sieve_filter_chain_core
   import psf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  field_type req_value,
   input  logic      req_restart,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output field_type rsp_prime_value,
   output logic      rsp_overflow
);

   cell_ctrl_type ctrl;
   cell_link_type link [MAX_PRIMES+1];

   assign link[0].valid = 1'b1;
   assign link[0].hit   = 1'b0;

   psf_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_value (rsp_prime_value),
      .rsp_overflow    (rsp_overflow),
      .tail            (link[MAX_PRIMES]),
      .ctrl            (ctrl)
   );

   for (genvar i = 0; i < MAX_PRIMES; i++) begin : g_cell
      psf_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .prev  (link[i]),
         .next  (link[i+1])
      );
   end

endmodule

/* src/psf_checker.sv */
// port-level checks for the prime sieve filter chain, bound to the top level
// uses psf_pkg and assert_macros.svh
`include "assert_macros.svh"

module psf_checker
   import psf_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input field_type req_value,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input field_type rsp_prime_value,
   input logic      rsp_overflow
);

   logic rsp_wait;
   logic req_start;

   assign rsp_wait  = rsp_valid && !rsp_ready;
   assign req_start = req_valid && req_ready && (req_value > field_type'(1));

   `CHK_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable({rsp_prime_value, rsp_overflow}))
   `CHK_ASSERT(a_rsp_min, rsp_valid, rsp_prime_value > field_type'(1))
   `CHK_ASSERT_NEXT(a_busy_after_start, req_start, !req_ready)
   `CHK_ASSERT(a_rsp_rise_idle, $rose(rsp_valid), req_ready)

endmodule

bind prime_sieve_filter_chain_core psf_checker u_psf_checker (.*);

/* bench/tb.sv */
// testbench for prime_sieve_filter_chain_core: directed and random candidate streams
// checked beat by beat against an in-bench sieve model held in a small scoreboard class
// depends on psf_pkg and the core rtl only
`timescale 1ns / 100ps

module tb
   import psf_pkg::*;
();

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 420;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      field_type prime_value;
      logic      overflow;
   } prime_beat_type;

   typedef struct packed {
      field_type value;
      logic      restart;
   } candidate_type;

   class sieve_scoreboard_type;
      value_type      found_primes[MAX_PRIMES];
      int unsigned    found_count;
      prime_beat_type expected_primes[$];
      int unsigned    mismatches;

      function new();
         found_count = 0;
         mismatches  = 0;
      endfunction

      function void note_candidate(field_type value, logic restart);
         value_type      v;
         bit             divided;
         prime_beat_type beat;
         v       = value_type'(value);
         divided = 1'b0;
         if (restart) begin
            found_count = 0;
         end
         if (v < 2) begin
            return;
         end
         for (int i = 0; i < found_count; i++) begin
            if (v % found_primes[i] == 0) begin
               divided = 1'b1;
            end
         end
         if (divided) begin
            return;
         end
         beat.overflow = (found_count == MAX_PRIMES);
         if (!beat.overflow) begin
            found_primes[found_count] = v;
            found_count++;
         end
         beat.prime_value = field_type'(v);
         expected_primes.push_back(beat);
      endfunction

      function void check_prime(field_type prime_value, logic overflow);
         prime_beat_type want;
         if (expected_primes.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected rsp beat, expected none, actual value %0d overflow %0b",
                     $time, prime_value, overflow);
            return;
         end
         want = expected_primes.pop_front();
         if (prime_value !== want.prime_value) begin
            mismatches++;
            $display("%0t: rsp_prime_value mismatch, expected %0d, actual %0d",
                     $time, want.prime_value, prime_value);
         end
         if (overflow !== want.overflow) begin
            mismatches++;
            $display("%0t: rsp_overflow mismatch, expected %0b, actual %0b",
                     $time, want.overflow, overflow);
         end
      endfunction

      function int unsigned pending();
         return expected_primes.size();
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   field_type req_value = '0;
   logic      req_restart = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   field_type rsp_prime_value;
   logic      rsp_overflow;

   int send_idle_pct = 20;
   int recv_idle_pct = 87;
   bit long_run_done = 1'b0;

   sieve_scoreboard_type sieve = new();

   candidate_type directed_set[17] = '{
      '{16'd0, 1'b1}, '{16'd1, 1'b0}, '{16'd2, 1'b0}, '{16'd2, 1'b0},
      '{16'd3, 1'b0}, '{16'd4, 1'b0}, '{16'd5, 1'b0}, '{16'd65535, 1'b0},
      '{16'd65521, 1'b0}, '{16'd7, 1'b0}, '{16'd49, 1'b0}, '{16'd1, 1'b1},
      '{16'd65535, 1'b1}, '{16'd32768, 1'b0}, '{16'd0, 1'b0},
      '{16'hAAAA, 1'b1}, '{16'h5555, 1'b0}
   };

   prime_sieve_filter_chain_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_value (rsp_prime_value),
      .rsp_overflow    (rsp_overflow)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sieve.check_prime(rsp_prime_value, rsp_overflow);
      end
   end

   // entered and left at a falling edge; valid stays up if the next beat follows at once
   task automatic feed_candidate(input field_type value, input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= value;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      sieve.note_candidate(value, restart);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sieve.pending() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct);
      int unsigned sent;
      int unsigned kind;
      int unsigned value;
      int unsigned last;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      sent          = 0;
      while (sent < PHASE_ITEMS) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            // well-formed stream from two; long ones fill the store and overflow
            if (!long_run_done || $urandom_range(3) == 0) begin
               last          = $urandom_range(450, 330);
               long_run_done = 1'b1;
            end else begin
               last = $urandom_range(200, 10);
            end
            value = 2;
            feed_candidate(field_type'(value), 1'b1);
            sent++;
            while (value < last && sent < PHASE_ITEMS) begin
               value += ($urandom_range(9) == 0) ? $urandom_range(4, 2) : 1;
               feed_candidate(field_type'(value), 1'b0);
               sent++;
            end
         end else if (kind < 85) begin
            repeat ($urandom_range(20, 1)) begin
               if (sent < PHASE_ITEMS) begin
                  value = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(65535);
                  feed_candidate(field_type'(value), ($urandom_range(15) == 0));
                  sent++;
               end
            end
         end else begin
            // ascending but not started from two and without restart
            value = $urandom_range(2000, 3);
            last  = value + $urandom_range(60, 5);
            while (value < last && sent < PHASE_ITEMS) begin
               feed_candidate(field_type'(value), 1'b0);
               value++;
               sent++;
            end
         end
         if ($urandom_range(19) == 0) begin
            drain_results();
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_set[i]) begin
         feed_candidate(directed_set[i].value, directed_set[i].restart);
      end
      drain_results();
      run_phase(20, 87);
      run_phase(87, 20);
      run_phase(0, 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sieve.mismatches == 0 && sieve.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/psf_pkg.sv
src/psf_cell.sv
src/psf_ctrl.sv
src/prime_sieve_filter_chain_core.sv
src/psf_checker.sv
bench/tb.sv
